/* rtl/core/usv_pkg.sv */
// Package: shared types and constants for the UTF-8 stream sanitizer.
`timescale 1ns / 1ps

package usv_pkg;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Depth of the held sequence store (lead plus up to two continuations)
  localparam int HeldDepth = 3;

  // Byte class patterns
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  // Sequence lengths; zero means no sequence open
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // One input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
  } result_t;

  // All results caused by one input item, as one queue entry
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes in emit order, index 0 first
    logic [1:0]      last_idx;  // index of the last result
    logic            has_byte;  // zero for a bare end marker
    logic            fin;       // last result closes the string
  } burst_t;

endpackage

/* rtl/core/usv_front.sv */
// Front end: classifies input bytes, tracks the open sequence, builds bursts.
`timescale 1ns / 1ps

module usv_front import usv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  item_t  item,
  output logic   burst_valid,
  output burst_t burst
);

  logic [7:0] held_bytes      [HeldDepth];
  logic [7:0] held_bytes_next [HeldDepth];
  logic [1:0] held_count, held_count_next;
  logic [2:0] exp_len, exp_len_next;

  logic [7:0] b;
  logic       is_cont;
  logic       judge;
  logic       complete;

  assign b        = item.in_byte;
  assign is_cont  = (b[7:6] == ContTag);
  assign complete = (({1'b0, held_count} + 3'd1) >= exp_len);

  // Sequence tracking and burst assembly
  always_comb begin
    for (int i = 0; i < HeldDepth; i++) begin
      held_bytes_next[i] = held_bytes[i];
    end
    held_count_next = held_count;
    exp_len_next    = exp_len;
    judge           = 1'b1;
    burst_valid     = 1'b0;
    burst           = '0;

    if (exp_len != SeqNone) begin
      if (is_cont) begin
        judge = 1'b0;
        if (complete) begin
          // emit the held bytes followed by this one
          for (int i = 0; i < HeldDepth; i++) begin
            burst.bytes[i] = held_bytes[i];
          end
          burst.bytes[held_count] = b;
          burst.last_idx          = held_count;
          burst.has_byte          = 1'b1;
          burst_valid             = 1'b1;
          held_count_next         = 2'd0;
          exp_len_next            = SeqNone;
        end else if (held_count != 2'd3) begin
          for (int i = 0; i < HeldDepth; i++) begin
            if (2'(i) == held_count) begin
              held_bytes_next[i] = b;
            end
          end
          held_count_next = held_count + 2'd1;
        end else begin
          held_count_next = 2'd0;
          exp_len_next    = SeqNone;
        end
      end else begin
        // broken sequence: discard and judge this byte afresh
        held_count_next = 2'd0;
        exp_len_next    = SeqNone;
      end
    end

    if (judge) begin
      if (!b[7]) begin
        burst.bytes[0] = b;
        burst.last_idx = 2'd0;
        burst.has_byte = 1'b1;
        burst_valid    = 1'b1;
      end else if (b[7:5] == Lead2Tag) begin
        held_bytes_next[0] = b;
        held_count_next    = 2'd1;
        exp_len_next       = SeqLen2;
      end else if (b[7:4] == Lead3Tag) begin
        held_bytes_next[0] = b;
        held_count_next    = 2'd1;
        exp_len_next       = SeqLen3;
      end else if (b[7:3] == Lead4Tag) begin
        held_bytes_next[0] = b;
        held_count_next    = 2'd1;
        exp_len_next       = SeqLen4;
      end
    end

    // end of string: drop any open sequence, mark the last result
    if (item.in_final) begin
      held_count_next = 2'd0;
      exp_len_next    = SeqNone;
      if (!burst_valid) begin
        burst.bytes    = '0;
        burst.last_idx = 2'd0;
        burst.has_byte = 1'b0;
        burst_valid    = 1'b1;
      end
      burst.fin = 1'b1;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      exp_len    <= SeqNone;
    end else if (accept) begin
      held_count <= held_count_next;
      exp_len    <= exp_len_next;
    end
  end

  // Held bytes carry no reset; only entries written since the lead are read
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HeldDepth; i++) begin
        held_bytes[i] <= held_bytes_next[i];
      end
    end
  end

endmodule

/* rtl/core/usv_queue.sv */
// Burst queue between the front end and the back end.
`timescale 1ns / 1ps

module usv_queue import usv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  burst_t wr_data,
  output logic   full,
  input  logic   rd,
  output logic   nonempty,
  output burst_t rd_data
);

  burst_t                mem [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  do_wr, do_rd;

  assign full     = (count == QueueCntW'(QueueDepth));
  assign nonempty = (count != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rd_data  = mem[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/usv_back.sv */
// Back end: expands each burst into single results behind an output register.
`timescale 1ns / 1ps

module usv_back import usv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_nonempty,
  input  burst_t  q_data,
  output logic    q_rd,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic       out_valid;
  result_t    out_data;
  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = q_nonempty && (!out_valid || pop);
  assign at_last = (idx == q_data.last_idx);
  assign q_rd    = load && at_last;
  assign empty   = !out_valid;
  assign result  = out_data;

  // Output register and burst index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte   <= q_data.bytes[idx];
      out_data.has_byte   <= q_data.has_byte;
      out_data.run_last   <= at_last;
      out_data.string_end <= at_last && q_data.fin;
    end
  end

endmodule

/* rtl/core/utf8_stream_sanitizer.sv */
// Top level: UTF-8 stream sanitizer, front end, burst queue and back end.
`timescale 1ns / 1ps

//  channel   handshake       payload            transaction when
//  input     push / full     item   (item_t)    push && !full
//  result    empty / pop     result (result_t)  pop && !empty
//
//  An input byte is taken every cycle while the burst queue has room.
//  Results leave one per cycle while pop is high; a completed sequence gives up to four.
//  Output rate is set by the back end, one result per cycle while pop is high.
//  A result passes through the burst queue and then the output register before it is on the ports.
//  rst is synchronous; it clears the open sequence, queue and output register.
//  A stalled result side fills the four-entry queue, then full rises.

module utf8_stream_sanitizer import usv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic   accept;
  logic   burst_valid;
  burst_t burst;
  logic   q_nonempty;
  logic   q_rd;
  burst_t q_data;

  assign accept = push && !full;

  usv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .burst_valid (burst_valid),
    .burst       (burst)
  );

  usv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept && burst_valid),
    .wr_data  (burst),
    .full     (full),
    .rd       (q_rd),
    .nonempty (q_nonempty),
    .rd_data  (q_data)
  );

  usv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

/* rtl/core/usv_checker.sv */
// Port-level checker for the UTF-8 stream sanitizer, bound to the top level.
`timescale 1ns / 1ps

module usv_checker import usv_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input item_t   item,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // A bare end marker is zero and closes both the run and the string
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.has_byte) |->
      (result.out_byte == 8'h00 && result.run_last && result.string_end))
    else $error("malformed end marker");

  // The end of a string is always the last result of its input transaction
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.string_end) |-> result.run_last)
    else $error("string end not on last result of its run");

endmodule

bind utf8_stream_sanitizer usv_checker u_usv_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

/* tb/tb_utf8_stream_sanitizer.sv */
// Testbench for the UTF-8 stream sanitizer: directed and random byte strings, checked per result.
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;
  import usv_pkg::*;

  localparam int CycleLimit = 200000;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  utf8_stream_sanitizer u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Expected results, oldest first
  result_t sanitized_q[$];
  int      errors = 0;
  int      cycles = 0;

  // Predictor state: open sequence
  logic [7:0] held_seq [HeldDepth];
  logic [1:0] held_cnt;
  logic [2:0] seq_len;

  // Sender idling
  bit idle_on    = 1'b1;
  int burst_left = 0;

  // Receiver stall pattern
  int rx_mode = 0;
  int rx_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t byte_result(input logic [7:0] b);
    result_t r;
    r.out_byte   = b;
    r.has_byte   = 1'b1;
    r.run_last   = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted byte and queue them
  task automatic predict_sanitized(input item_t it);
    result_t    outs[$];
    result_t    marker;
    logic [7:0] b;
    bit         judge;
    int         last;
    b     = it.in_byte;
    judge = 1'b1;
    if (seq_len != SeqNone) begin
      if (b[7:6] == ContTag) begin
        judge = 1'b0;
        if (int'(held_cnt) + 1 >= int'(seq_len)) begin
          // sequence complete: flush held bytes and this one
          for (int i = 0; i < int'(held_cnt) && i < HeldDepth; i++)
            outs = {outs, byte_result(held_seq[i])};
          outs = {outs, byte_result(b)};
          held_cnt = 2'd0;
          seq_len  = SeqNone;
        end else if (int'(held_cnt) < HeldDepth) begin
          held_seq[held_cnt] = b;
          held_cnt = held_cnt + 2'd1;
        end else begin
          held_cnt = 2'd0;
          seq_len  = SeqNone;
        end
      end else begin
        // broken sequence, byte judged afresh below
        held_cnt = 2'd0;
        seq_len  = SeqNone;
      end
    end
    if (judge) begin
      if (b[7] == 1'b0) begin
        outs = {outs, byte_result(b)};
      end else if (b[7:5] == Lead2Tag) begin
        held_seq[0] = b; held_cnt = 2'd1; seq_len = SeqLen2;
      end else if (b[7:4] == Lead3Tag) begin
        held_seq[0] = b; held_cnt = 2'd1; seq_len = SeqLen3;
      end else if (b[7:3] == Lead4Tag) begin
        held_seq[0] = b; held_cnt = 2'd1; seq_len = SeqLen4;
      end
    end
    if (it.in_final) begin
      held_cnt = 2'd0;
      seq_len  = SeqNone;
      if (outs.size() == 0) begin
        marker = '0;
        outs = {outs, marker};
      end
      outs[outs.size() - 1].string_end = 1'b1;
    end
    if (outs.size() > 0) begin
      last = outs.size() - 1;
      outs[last].run_last = 1'b1;
    end
    foreach (outs[i]) sanitized_q = {sanitized_q, outs[i]};
  endtask

  // Offer one byte until accepted; push stays high into the next call unless a gap starts
  task automatic send_byte(input logic [7:0] b, input logic fin);
    item_t it;
    it.in_byte  = b;
    it.in_final = fin;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_sanitized(it);
    if (idle_on) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Hold the sender until every expected result has come
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sanitized_q.size() != 0) @(posedge clk);
  endtask

  // One random character; a broken one is cut short or is a stray or invalid byte
  task automatic send_char(input bit fin, input bit broken);
    logic [7:0]  seq [4];
    logic [31:0] r;
    int          len;
    int          n;
    r = $urandom;
    case ($urandom_range(0, 9)) inside
      [0:3]:   begin len = 1; seq[0] = {1'b0, r[6:0]}; end
      [4:5]:   begin len = 2; seq[0] = {Lead2Tag, r[4:0]}; end
      [6:7]:   begin len = 3; seq[0] = {Lead3Tag, r[3:0]}; end
      default: begin len = 4; seq[0] = {Lead4Tag, r[2:0]}; end
    endcase
    for (int i = 1; i < len; i++) begin
      r = $urandom;
      seq[i] = {ContTag, r[5:0]};
    end
    n = len;
    if (broken) begin
      if (len > 1) begin
        n = $urandom_range(1, len - 1);
      end else begin
        r = $urandom;
        seq[0] = r[8] ? {ContTag, r[5:0]} : (8'hF8 | {5'd0, r[2:0]});
      end
    end
    for (int i = 0; i < n; i++) send_byte(seq[i], fin && (i == n - 1));
  endtask

  // Extremes of each byte class and every special case
  task automatic test_directed_cases();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);   // two-byte, overlong allowed
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);   // three-byte
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0);   // four-byte, highest lead
    send_byte(8'hBF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);   // invalid leads
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);   // broken by ASCII
    send_byte(8'h41, 1'b0);
    send_byte(8'hDF, 1'b0);   // broken by a new lead
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);   // incomplete at end of string
    send_byte(8'h90, 1'b1);
    send_byte(8'h41, 1'b1);   // end on a passed byte
    send_byte(8'h80, 1'b1);   // end with nothing passed
  endtask

  // Strings of mostly well-formed characters with some damage
  task automatic test_wellformed_strings(input int n_strings);
    int nchars;
    for (int s = 0; s < n_strings; s++) begin
      nchars = $urandom_range(1, 8);
      for (int c = 0; c < nchars; c++)
        send_char(c == nchars - 1, $urandom_range(0, 99) < 15);
    end
  endtask

  // Pause mid-sequence until the result side has caught up
  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) begin
      send_char(1'b0, 1'b0);
      send_byte(8'hE3, 1'b0);
      drain_results();
      send_byte(8'h81, 1'b0);
      drain_results();
      send_byte(8'h82, 1'b1);
    end
  endtask

  // Sender without gaps
  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_wellformed_strings(5);
    idle_on = 1'b1;
  endtask

  // Fully random bytes and end flags
  task automatic test_raw_noise(input int n_items);
    logic [31:0] r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom;
      send_byte(r[7:0], r[12:8] == 5'd0);
    end
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (sanitized_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte=%h has=%b last=%b end=%b",
                 $time, result.out_byte, result.has_byte, result.run_last, result.string_end);
        errors++;
      end else begin
        want = sanitized_q.pop_front();
        if (result.has_byte !== want.has_byte || result.run_last !== want.run_last ||
            result.string_end !== want.string_end ||
            (want.has_byte && result.out_byte !== want.out_byte)) begin
          $display("%0t: expected byte=%h has=%b last=%b end=%b, actual byte=%h has=%b last=%b end=%b",
                   $time, want.out_byte, want.has_byte, want.run_last, want.string_end,
                   result.out_byte, result.has_byte, result.run_last, result.string_end);
          errors++;
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(8, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= $urandom_range(0, 1);
      default: pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst  = 1'b1;
    push = 1'b0;
    item = '0;
    foreach (held_seq[i]) held_seq[i] = 8'h00;
    held_cnt = 2'd0;
    seq_len  = SeqNone;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_wellformed_strings(10);
    test_drain_pause();
    test_back_to_back();
    test_raw_noise(60);
    test_wellformed_strings(9);
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
